>>> rtl/mpct_pkg.sv
`default_nettype none

package mpct_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BTN_W    = 3;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned SCREEN_W = 13;
    localparam int unsigned CSIZE_W  = 7;
    localparam int unsigned DX_W     = 9;
    localparam int unsigned DY_W     = 10;
    localparam int unsigned SUM_W    = 14;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CSIZE_W-1:0] CURSOR_WIDTH  = 7'd10;
    localparam logic [CSIZE_W-1:0] CURSOR_HEIGHT = 7'd17;

    localparam logic [SCREEN_W-1:0] SCREEN_W_RESET = 13'd800;
    localparam logic [SCREEN_W-1:0] SCREEN_H_RESET = 13'd480;

    localparam logic [POS_W-1:0] CURSOR_X_RESET = SCREEN_W_RESET[POS_W:1];
    localparam logic [POS_W-1:0] CURSOR_Y_RESET = SCREEN_H_RESET[POS_W:1];
    localparam logic [POS_W-1:0] POS_MAX        = '1;

    localparam logic [BTN_W-1:0] BTN_LEFT_ONLY = 3'b001;
    localparam int unsigned SIGN_X_BIT = 4;
    localparam int unsigned SIGN_Y_BIT = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } limits_t;

    // Largest cursor position: screen size minus cursor size, held to 0..4095
    function automatic logic [POS_W-1:0] axis_limit(
        input logic [SCREEN_W-1:0] size,
        input logic [CSIZE_W-1:0]  csize
    );
        logic signed [SUM_W-1:0] d;
        d = $signed({1'b0, size}) - $signed({{(SUM_W-CSIZE_W){1'b0}}, csize});
        if (d < 0)
            return '0;
        else if (d > $signed({{(SUM_W-POS_W){1'b0}}, POS_MAX}))
            return POS_MAX;
        else
            return d[POS_W-1:0];
    endfunction

    // Raise to 0 first, then lower to the limit
    function automatic logic [POS_W-1:0] move_clamp(
        input logic [POS_W-1:0]        pos,
        input logic signed [DY_W-1:0]  delta,
        input logic [POS_W-1:0]        lim
    );
        logic signed [SUM_W-1:0] p;
        p = $signed({{(SUM_W-POS_W){1'b0}}, pos})
            + $signed({{(SUM_W-DY_W){delta[DY_W-1]}}, delta});
        if (p < 0)
            return '0;
        else if (p > $signed({{(SUM_W-POS_W){1'b0}}, lim}))
            return lim;
        else
            return p[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/mpct_if.sv
`default_nettype none

interface mpct_in_if;
    logic                          valid;
    logic                          ready;
    logic [mpct_pkg::BYTE_W-1:0]   report_byte;

    modport source (output valid, output report_byte, input ready);
    modport sink   (input valid, input report_byte, output ready);
endinterface

interface mpct_out_if;
    logic                          valid;
    logic                          ready;
    logic [mpct_pkg::BTN_W-1:0]    buttons;
    logic [mpct_pkg::POS_W-1:0]    pos_x;
    logic [mpct_pkg::POS_W-1:0]    pos_y;
    logic                          click;

    modport source (output valid, output buttons, output pos_x, output pos_y,
                    output click, input ready);
    modport sink   (input valid, input buttons, input pos_x, input pos_y,
                    input click, output ready);
endinterface

`default_nettype wire

>>> rtl/mpct_cfg.sv
`default_nettype none

module mpct_cfg
#(
    parameter logic [mpct_pkg::CSIZE_W-1:0] CURSOR_WIDTH  = mpct_pkg::CURSOR_WIDTH,
    parameter logic [mpct_pkg::CSIZE_W-1:0] CURSOR_HEIGHT = mpct_pkg::CURSOR_HEIGHT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mpct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mpct_pkg::SCREEN_W-1:0]     cfg_wdata,
    output mpct_pkg::limits_t                      limits
);

    localparam logic [mpct_pkg::POS_W-1:0] LIM_X_RESET =
        mpct_pkg::axis_limit(mpct_pkg::SCREEN_W_RESET, CURSOR_WIDTH);
    localparam logic [mpct_pkg::POS_W-1:0] LIM_Y_RESET =
        mpct_pkg::axis_limit(mpct_pkg::SCREEN_H_RESET, CURSOR_HEIGHT);

    mpct_pkg::limits_t limits_reg;
    mpct_pkg::limits_t limits_next;

    // Limits are worked out once, at the write
    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_we)
        begin
            unique case (mpct_pkg::cfg_reg_t'(cfg_index))
                mpct_pkg::REG_SCREEN_WIDTH:
                    limits_next.x = mpct_pkg::axis_limit(cfg_wdata, CURSOR_WIDTH);
                mpct_pkg::REG_SCREEN_HEIGHT:
                    limits_next.y = mpct_pkg::axis_limit(cfg_wdata, CURSOR_HEIGHT);
                default:
                    limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.x <= LIM_X_RESET;
            limits_reg.y <= LIM_Y_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

`default_nettype wire

>>> rtl/mpct_core.sv
`default_nettype none

module mpct_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mpct_pkg::limits_t limits,
    mpct_in_if.sink            in_ch,
    mpct_out_if.source         out_ch
);

    typedef enum logic [1:0] {
        ST_HEADER = 2'd0,
        ST_DX     = 2'd1,
        ST_DY     = 2'd2
    } byte_state_t;

    byte_state_t                   state_reg, state_next;
    logic                          in_valid_reg;
    logic [mpct_pkg::BYTE_W-1:0]   byte_reg;
    logic [mpct_pkg::BYTE_W-1:0]   header_reg, header_next;
    logic [mpct_pkg::BYTE_W-1:0]   dx_byte_reg, dx_byte_next;
    logic [mpct_pkg::POS_W-1:0]    cursor_x_reg, cursor_x_next;
    logic [mpct_pkg::POS_W-1:0]    cursor_y_reg, cursor_y_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mpct_pkg::BTN_W-1:0]    buttons_reg, buttons_next;
    logic                          click_reg, click_next;
    logic                          advance;
    logic                          in_ready;
    logic [mpct_pkg::BTN_W-1:0]    btn;
    logic signed [mpct_pkg::DY_W-1:0] dx;
    logic signed [mpct_pkg::DY_W-1:0] dy;

    assign advance  = !out_valid_reg || out_ch.ready;
    assign in_ready = !in_valid_reg || advance;

    assign btn = header_reg[mpct_pkg::BTN_W-1:0];
    assign dx  = $signed({header_reg[mpct_pkg::SIGN_X_BIT],
                          header_reg[mpct_pkg::SIGN_X_BIT], dx_byte_reg});
    assign dy  = $signed({1'b0, header_reg[mpct_pkg::SIGN_Y_BIT],
                          {mpct_pkg::BYTE_W{1'b0}}})
               - $signed({2'b00, byte_reg});

    always_comb
    begin
        state_next     = state_reg;
        header_next    = header_reg;
        dx_byte_next   = dx_byte_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        out_valid_next = out_valid_reg;
        buttons_next   = buttons_reg;
        click_next     = click_reg;
        if (advance)
        begin
            out_valid_next = 1'b0;
            if (in_valid_reg)
            begin
                unique case (state_reg)
                    ST_DX:
                    begin
                        dx_byte_next = byte_reg;
                        state_next   = ST_DY;
                    end
                    ST_DY:
                    begin
                        state_next     = ST_HEADER;
                        out_valid_next = 1'b1;
                        buttons_next   = btn;
                        click_next     = (btn == mpct_pkg::BTN_LEFT_ONLY);
                        if (btn != mpct_pkg::BTN_LEFT_ONLY)
                        begin
                            cursor_x_next = mpct_pkg::move_clamp(cursor_x_reg, dx, limits.x);
                            cursor_y_next = mpct_pkg::move_clamp(cursor_y_reg, dy, limits.y);
                        end
                    end
                    default:
                    begin
                        // header byte, also restarts framing from the unused code
                        header_next = byte_reg;
                        state_next  = ST_DX;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEADER;
            in_valid_reg  <= 1'b0;
            header_reg    <= '0;
            dx_byte_reg   <= '0;
            cursor_x_reg  <= mpct_pkg::CURSOR_X_RESET;
            cursor_y_reg  <= mpct_pkg::CURSOR_Y_RESET;
            out_valid_reg <= 1'b0;
            buttons_reg   <= '0;
            click_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_ch.valid;
            state_reg     <= state_next;
            header_reg    <= header_next;
            dx_byte_reg   <= dx_byte_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
            buttons_reg   <= buttons_next;
            click_reg     <= click_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
            byte_reg <= in_ch.report_byte;
    end

    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.buttons = buttons_reg;
    assign out_ch.pos_x   = cursor_x_reg;
    assign out_ch.pos_y   = cursor_y_reg;
    assign out_ch.click   = click_reg;

endmodule

`default_nettype wire

>>> rtl/mouse_packet_cursor_tracker.sv
// Frames mouse report bytes into three-byte packets (header, X delta, Y delta)
// and gives one result per packet: buttons, clamped cursor position and a click
// flag for a left-only press, which holds the cursor. One byte is taken every
// clock cycle; the input stalls only while a finished result waits in the
// output register. A result passes through the input register, then the
// result register, after its third byte is taken. Screen size writes update
// the position limits at once and take effect on the next moving packet.
`default_nettype none

module mouse_packet_cursor_tracker
#(
    parameter logic [mpct_pkg::CSIZE_W-1:0] CURSOR_WIDTH  = mpct_pkg::CURSOR_WIDTH,
    parameter logic [mpct_pkg::CSIZE_W-1:0] CURSOR_HEIGHT = mpct_pkg::CURSOR_HEIGHT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mpct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mpct_pkg::SCREEN_W-1:0]     cfg_wdata,
    mpct_in_if.sink                                in_ch,
    mpct_out_if.source                             out_ch
);

    mpct_pkg::limits_t limits;

    mpct_cfg
    #(
        .CURSOR_WIDTH  (CURSOR_WIDTH),
        .CURSOR_HEIGHT (CURSOR_HEIGHT)
    )
    u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .limits    (limits)
    );

    mpct_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .limits (limits),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

>>> rtl/mpct_checker.sv
`default_nettype none

module mpct_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_ready,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [mpct_pkg::BTN_W-1:0]     buttons,
    input  wire logic [mpct_pkg::POS_W-1:0]     pos_x,
    input  wire logic [mpct_pkg::POS_W-1:0]     pos_y,
    input  wire logic                           click
);

    logic [mpct_pkg::POS_W-1:0] last_x_reg;
    logic [mpct_pkg::POS_W-1:0] last_y_reg;

    // position of the last delivered transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= mpct_pkg::CURSOR_X_RESET;
            last_y_reg <= mpct_pkg::CURSOR_Y_RESET;
        end
        else if (out_valid && out_ready)
        begin
            last_x_reg <= pos_x;
            last_y_reg <= pos_y;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_click_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (click == (buttons == mpct_pkg::BTN_LEFT_ONLY)))
        else $error("click flag does not match left-only buttons");

    a_click_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && click |-> (pos_x == last_x_reg) && (pos_y == last_y_reg))
        else $error("cursor moved on a click packet");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .buttons   (out_ch.buttons),
    .pos_x     (out_ch.pos_x),
    .pos_y     (out_ch.pos_y),
    .click     (out_ch.click)
);

`default_nettype wire
